>>> rtl/chd_pkg.sv
// Shared types and constants for the canonical Huffman bit decoder.
// No dependencies; imported by every module of the block.
package chd_pkg;

    localparam int MAX_CODE_BITS_DEF = 15;
    localparam int MAX_SYMBOLS_DEF   = 1024;

    // Field widths fixed by the stream format
    localparam int OP_W        = 2;
    localparam int LEN_FIELD_W = 4;
    localparam int COUNT_W     = 11;
    localparam int SYM_W       = 10;
    localparam int STATUS_W    = 2;

    localparam int S_TDATA_W = 16;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 16;
    localparam int M_TUSER_W = 2;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD   = 2'd0,
        OP_DECODE = 2'd1,
        OP_END    = 2'd2
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_SYMBOL       = 2'd0,
        ST_OUT_OF_CODES = 2'd1,
        ST_INCOMPLETE   = 2'd2,
        ST_CLEAN_END    = 2'd3
    } status_t;

    typedef struct packed {
        op_t                    op;
        logic [LEN_FIELD_W-1:0] code_length;
        logic [COUNT_W-1:0]     count_value;
        logic                   in_bit;
    } item_t;

    typedef struct packed {
        logic             valid;
        logic [SYM_W-1:0] symbol_index;
        status_t          status;
    } result_t;

    typedef struct packed {
        logic                   en;
        logic [LEN_FIELD_W-1:0] len;
        logic [COUNT_W-1:0]     count;
    } tbl_wr_t;

endpackage

>>> rtl/chd_len_table.sv
// Table of code counts per code length, with saturation on write.
// Depends on chd_pkg.
module chd_len_table #(
    parameter int MAX_CODE_BITS = chd_pkg::MAX_CODE_BITS_DEF,
    parameter int MAX_SYMBOLS   = chd_pkg::MAX_SYMBOLS_DEF,
    parameter int LEN_W         = $clog2(MAX_CODE_BITS + 1)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  chd_pkg::tbl_wr_t            wr,
    input  logic [LEN_W-1:0]            rd_len,
    output logic [chd_pkg::COUNT_W-1:0] rd_count
);
    import chd_pkg::*;

    localparam int IDX_W = (MAX_CODE_BITS > 1) ? $clog2(MAX_CODE_BITS) : 1;
    localparam logic [16:0] SAT = 17'(MAX_SYMBOLS);

    logic [COUNT_W-1:0] counts_reg [MAX_CODE_BITS];
    logic [5:0]         wr_len_ext;
    logic               wr_ok;
    logic [IDX_W-1:0]   wr_idx;
    logic [IDX_W-1:0]   rd_idx;
    logic [COUNT_W-1:0] wr_sat;

    assign wr_len_ext = {2'b00, wr.len};
    assign wr_ok      = (wr_len_ext != 6'd0) && (wr_len_ext <= 6'(MAX_CODE_BITS));
    assign wr_idx     = IDX_W'(wr_len_ext - 6'd1);
    assign rd_idx     = IDX_W'(rd_len - LEN_W'(1));
    assign wr_sat     = ({6'b0, wr.count} > SAT) ? COUNT_W'(SAT) : wr.count;
    assign rd_count   = counts_reg[rd_idx];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_CODE_BITS; i++)
            begin
                counts_reg[i] <= '0;
            end
        end
        else if (wr.en && wr_ok)
        begin
            counts_reg[wr_idx] <= wr_sat;
        end
    end

endmodule

>>> rtl/chd_decode.sv
// Decoder state (length, partial code, first code, base index) and the
// per-item update. Depends on chd_pkg; reads counts from chd_len_table.
module chd_decode #(
    parameter int MAX_CODE_BITS = chd_pkg::MAX_CODE_BITS_DEF,
    parameter int LEN_W         = $clog2(MAX_CODE_BITS + 1)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        go,
    input  chd_pkg::item_t              item,
    input  logic [chd_pkg::COUNT_W-1:0] rd_count,
    output logic [LEN_W-1:0]            rd_len,
    output chd_pkg::tbl_wr_t            tbl_wr,
    output chd_pkg::result_t            result
);
    import chd_pkg::*;

    // A code of length L is below 2**L, so MAX_CODE_BITS bits hold it.
    localparam int CODE_W = MAX_CODE_BITS;
    localparam int SUM_W  = ((CODE_W > COUNT_W) ? CODE_W : COUNT_W) + 1;

    logic [LEN_W-1:0]  len_reg, len_next;
    logic [CODE_W-1:0] partial_reg, partial_next;
    logic [CODE_W-1:0] first_reg, first_next;
    logic [SYM_W-1:0]  base_reg, base_next;

    logic [CODE_W-1:0] code;
    logic [SUM_W-1:0]  range_end;
    logic              hit;
    logic              last_len;
    logic [SYM_W-1:0]  sym;

    assign rd_len    = len_reg;
    assign code      = partial_reg | CODE_W'(item.in_bit);
    assign range_end = SUM_W'(first_reg) + SUM_W'(rd_count);
    assign hit       = SUM_W'(code) < range_end;
    assign last_len  = (len_reg == LEN_W'(MAX_CODE_BITS));
    assign sym       = base_reg + SYM_W'(code - first_reg);

    always_comb
    begin
        len_next       = len_reg;
        partial_next   = partial_reg;
        first_next     = first_reg;
        base_next      = base_reg;
        result         = '0;
        tbl_wr.en      = 1'b0;
        tbl_wr.len     = item.code_length;
        tbl_wr.count   = item.count_value;
        if (go)
        begin
            unique case (item.op)
                OP_LOAD:
                begin
                    tbl_wr.en    = 1'b1;
                    len_next     = LEN_W'(1);
                    partial_next = '0;
                    first_next   = '0;
                    base_next    = '0;
                end
                OP_DECODE:
                begin
                    if (hit || last_len)
                    begin
                        result.valid        = 1'b1;
                        result.symbol_index = hit ? sym : '0;
                        result.status       = hit ? ST_SYMBOL : ST_OUT_OF_CODES;
                        len_next            = LEN_W'(1);
                        partial_next        = '0;
                        first_next          = '0;
                        base_next           = '0;
                    end
                    else
                    begin
                        // no fit at this length: move range to next length
                        len_next     = len_reg + LEN_W'(1);
                        partial_next = CODE_W'({code, 1'b0});
                        first_next   = CODE_W'({range_end, 1'b0});
                        base_next    = base_reg + SYM_W'(rd_count);
                    end
                end
                OP_END:
                begin
                    result.valid = 1'b1;
                    if (len_reg == LEN_W'(1))
                    begin
                        result.status = ST_CLEAN_END;
                    end
                    else
                    begin
                        result.status = ST_INCOMPLETE;
                        len_next      = LEN_W'(1);
                        partial_next  = '0;
                        first_next    = '0;
                        base_next     = '0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg     <= LEN_W'(1);
            partial_reg <= '0;
            first_reg   <= '0;
            base_reg    <= '0;
        end
        else
        begin
            len_reg     <= len_next;
            partial_reg <= partial_next;
            first_reg   <= first_next;
            base_reg    <= base_next;
        end
    end

endmodule

>>> rtl/canonical_huffman_bit_decoder.sv
// Canonical Huffman bit decoder: one coded bit per input transfer. Load
// transfers (tuser = 0) write the number of codes of one length and restart
// the decoder; decode transfers (tuser = 1) shift in one bit; end transfers
// (tuser = 2) report a clean end (status 3) or an incomplete code (status 2).
// A decode transfer gives an output only on a decoded symbol (status 0) or when
// no code matches by length MAX_CODE_BITS (status 1). The block sustains one
// transfer per cycle while the output is not stalled: the decoder state loop
// (count table read, add, compare, state update) is combinational between the
// input register and the output register, which hold each transfer and its result.
// Depends on chd_pkg, chd_len_table and chd_decode.
module canonical_huffman_bit_decoder #(
    parameter int MAX_CODE_BITS = chd_pkg::MAX_CODE_BITS_DEF,
    parameter int MAX_SYMBOLS   = chd_pkg::MAX_SYMBOLS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [3:0] code_length, [14:4] count_value, [15] in_bit
    input  logic [chd_pkg::S_TDATA_W-1:0] s_tdata,
    // [1:0] operation
    input  logic [chd_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [9:0] symbol_index, [15:10] zero
    output logic [chd_pkg::M_TDATA_W-1:0] m_tdata,
    // [1:0] status
    output logic [chd_pkg::M_TUSER_W-1:0] m_tuser
);
    import chd_pkg::*;

    localparam int LEN_W = $clog2(MAX_CODE_BITS + 1);

    item_t            item_reg;
    item_t            item_in;
    logic             item_valid_reg, item_valid_next;
    logic             s_xfer;
    logic             advance;

    logic             out_valid_reg, out_valid_next;
    logic [SYM_W-1:0] out_sym_reg;
    status_t          out_status_reg;

    logic [LEN_W-1:0]   rd_len;
    logic [COUNT_W-1:0] rd_count;
    tbl_wr_t            tbl_wr;
    result_t            result;

    assign item_in.op          = op_t'(s_tuser[OP_W-1:0]);
    assign item_in.code_length = s_tdata[3:0];
    assign item_in.count_value = s_tdata[14:4];
    assign item_in.in_bit      = s_tdata[15];

    // The staged item is processed once the output register is free or
    // being drained this cycle.
    assign advance  = item_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !item_valid_reg || advance;
    assign s_xfer   = s_tvalid && s_tready;

    assign item_valid_next = s_xfer ? 1'b1 : (advance ? 1'b0 : item_valid_reg);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance && result.valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_xfer)
        begin
            item_reg <= item_in;
        end
        if (advance && result.valid)
        begin
            out_sym_reg    <= result.symbol_index;
            out_status_reg <= result.status;
        end
    end

    chd_len_table #(
        .MAX_CODE_BITS (MAX_CODE_BITS),
        .MAX_SYMBOLS   (MAX_SYMBOLS),
        .LEN_W         (LEN_W)
    ) u_len_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (tbl_wr),
        .rd_len   (rd_len),
        .rd_count (rd_count)
    );

    chd_decode #(
        .MAX_CODE_BITS (MAX_CODE_BITS),
        .LEN_W         (LEN_W)
    ) u_decode (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (advance),
        .item     (item_reg),
        .rd_count (rd_count),
        .rd_len   (rd_len),
        .tbl_wr   (tbl_wr),
        .result   (result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - SYM_W){1'b0}}, out_sym_reg};
    assign m_tuser  = M_TUSER_W'(out_status_reg);

endmodule

>>> rtl/chd_checker.sv
// Port-level checks for canonical_huffman_bit_decoder, bound to the top level.
// Depends on chd_pkg.
module chd_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [chd_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [chd_pkg::M_TUSER_W-1:0] m_tuser
);
    import chd_pkg::*;

    // stalled output holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output changed while stalled");

    // symbol field is zero on every status but a decoded symbol
    a_sym_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != M_TUSER_W'(ST_SYMBOL)) |-> (m_tdata[SYM_W-1:0] == '0))
        else $error("symbol index set on non-symbol status");

    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[M_TDATA_W-1:SYM_W] == '0))
        else $error("tdata padding not zero");

    // with the output empty the input side never stalls
    a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

endmodule

bind canonical_huffman_bit_decoder chd_checker u_chd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
